### sv/rru_pkg.sv
// package for the register rename unit: operation codes and checkpoint control
`timescale 1ns / 1ps

package rru_pkg;

    localparam int OP_W    = 3;
    localparam int TAG_W   = 4;
    localparam int AREG_W  = 6;
    localparam int PREG_W  = 7;

    typedef enum logic [OP_W-1:0] {
        OP_RENAME  = 3'd0,
        OP_COMMIT  = 3'd1,
        OP_WAKE    = 3'd2,
        OP_RECOVER = 3'd3,
        OP_FLUSH   = 3'd4
    } t_op;

    // checkpoint store control from the rename datapath
    typedef struct packed {
        logic             alloc_en;
        logic             save_en;
        logic [TAG_W-1:0] tag;
    } t_ckpt_ctl;

endpackage

### sv/rru_alloc.sv
// lowest free physical register search
`timescale 1ns / 1ps

module rru_alloc import rru_pkg::*; #(
    parameter int PHYS_REGS = 128,
    parameter int PW        = 7
) (
    input  logic [PHYS_REGS-1:0] i_free,
    output logic                 o_found,
    output logic [PW-1:0]        o_idx
);

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        // scan downward so the lowest set bit wins
        for (int p = PHYS_REGS - 1; p >= 0; p--) begin
            if (i_free[p]) begin
                o_found = 1'b1;
                o_idx   = PW'(p);
            end
        end
    end

endmodule

### sv/rru_ckpt.sv
// branch checkpoint store: saved speculative maps and allocation masks
`timescale 1ns / 1ps

module rru_ckpt import rru_pkg::*; #(
    parameter int PHYS_REGS   = 128,
    parameter int MAP_N       = 33,
    parameter int MW          = 7,
    parameter int PW          = 7,
    parameter int CHECKPOINTS = 16
) (
    input  logic                      i_clk,
    input  t_ckpt_ctl                 i_ctl,
    input  logic [PW-1:0]             i_alloc_idx,
    input  logic [MAP_N-1:0][MW-1:0]  i_map,
    input  logic [TAG_W-1:0]          i_rd_tag,
    output logic [MAP_N-1:0][MW-1:0]  o_map,
    output logic [PHYS_REGS-1:0]      o_mask
);

    localparam int CW = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;

    logic [MAP_N-1:0][MW-1:0]  r_maps [CHECKPOINTS];
    logic [PHYS_REGS-1:0]      r_masks [CHECKPOINTS];
    logic [CW-1:0]             w_wr_idx;
    logic [CW-1:0]             w_rd_idx;

    assign w_wr_idx = CW'(i_ctl.tag);
    assign w_rd_idx = CW'(i_rd_tag);

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < CHECKPOINTS; j++) begin
            if (i_ctl.save_en && w_wr_idx == CW'(j)) begin
                r_maps[j]  <= i_map;
                r_masks[j] <= '0;
            end else if (i_ctl.alloc_en) begin
                r_masks[j][i_alloc_idx] <= 1'b1;
            end
        end
    end

    assign o_map  = r_maps[w_rd_idx];
    assign o_mask = r_masks[w_rd_idx];

endmodule

### sv/register_rename_unit.sv
// register rename unit top level: rename tables, free list, busy table, result register
`timescale 1ns / 1ps
// a request's result is in the output register in the cycle after its acceptance
// throughput: one request per cycle while i_ready is high; the allocator priority
// search and the map lookups sit between the request port and the result register
// reset (synchronous, active low) sets both maps to the interleaved identity,
// frees every unmapped register and clears busy and in-flight bits

module register_rename_unit import rru_pkg::*; #(
    parameter int PHYS_REGS        = 128,
    parameter int ARCH_REGS        = 32,
    parameter int CHECKPOINTS      = 16,
    parameter int RESET_INTERLEAVE = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [OP_W-1:0]   i_op,
    input  logic [AREG_W-1:0] i_src_a_arch,
    input  logic [AREG_W-1:0] i_src_b_arch,
    input  logic [AREG_W-1:0] i_dest_arch,
    input  logic              i_has_dest,
    input  logic              i_take_ckpt,
    input  logic [TAG_W-1:0]  i_branch_tag,
    input  logic [PREG_W-1:0] i_phys_reg,
    input  logic [PREG_W-1:0] i_old_phys_reg,
    input  logic              i_no_free,
    input  logic              i_no_arch_update,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_accepted,
    output logic [PREG_W-1:0] o_new_dest,
    output logic [PREG_W-1:0] o_prev_dest,
    output logic [PREG_W-1:0] o_src_a_phys,
    output logic              o_src_a_busy,
    output logic [PREG_W-1:0] o_src_b_phys,
    output logic              o_src_b_busy
);

    localparam int MAP_N = ARCH_REGS + 1;
    localparam int PW    = $clog2(PHYS_REGS);
    localparam int MW    = (PW > PREG_W) ? PW : PREG_W;
    localparam int AW    = $clog2(MAP_N);

    logic [MAP_N-1:0][MW-1:0] r_spec, n_spec;
    logic [MAP_N-1:0][MW-1:0] r_arch, n_arch;
    logic [PHYS_REGS-1:0]     r_free, n_free;
    logic [PHYS_REGS-1:0]     r_inflight, n_inflight;
    logic [PHYS_REGS-1:0]     r_busy, n_busy;

    logic              r_out_valid;
    logic              r_accepted, n_accepted;
    logic [PREG_W-1:0] r_new_dest, n_new_dest;
    logic [PREG_W-1:0] r_prev_dest, n_prev_dest;
    logic [PREG_W-1:0] r_src_a_phys, n_src_a_phys;
    logic              r_src_a_busy, n_src_a_busy;
    logic [PREG_W-1:0] r_src_b_phys, n_src_b_phys;
    logic              r_src_b_busy, n_src_b_busy;

    logic [MAP_N-1:0][MW-1:0] w_rst_map;
    logic [PHYS_REGS-1:0]     w_rst_used;
    logic                     w_take;
    logic                     w_found;
    logic [PW-1:0]            w_nd;
    logic                     w_stall;
    t_ckpt_ctl                w_ctl;
    logic [MAP_N-1:0][MW-1:0] w_ck_map;
    logic [PHYS_REGS-1:0]     w_ck_mask;
    logic [MW-1:0]            w_pa, w_pb, w_prev;
    logic                     w_ba, w_bb;
    logic [PREG_W-1:0]        w_nd_out;

    genvar gi;
    generate
        for (gi = 0; gi < ARCH_REGS; gi++) begin : g_rst
            localparam int V = ((gi % RESET_INTERLEAVE) * (PHYS_REGS / RESET_INTERLEAVE)
                               + gi / RESET_INTERLEAVE) % PHYS_REGS;
            assign w_rst_map[gi] = MW'(V);
        end
    endgenerate
    assign w_rst_map[ARCH_REGS] = '0;

    always_comb begin
        w_rst_used = '0;
        for (int i = 0; i < ARCH_REGS; i++) begin
            w_rst_used[w_rst_map[i][PW-1:0]] = 1'b1;
        end
    end

    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    rru_alloc #(
        .PHYS_REGS (PHYS_REGS),
        .PW        (PW)
    ) u_alloc (
        .i_free  (r_free),
        .o_found (w_found),
        .o_idx   (w_nd)
    );

    rru_ckpt #(
        .PHYS_REGS   (PHYS_REGS),
        .MAP_N       (MAP_N),
        .MW          (MW),
        .PW          (PW),
        .CHECKPOINTS (CHECKPOINTS)
    ) u_ckpt (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_alloc_idx (w_nd),
        .i_map       (n_spec),
        .i_rd_tag    (i_branch_tag),
        .o_map       (w_ck_map),
        .o_mask      (w_ck_mask)
    );

    // source and destination lookups
    always_comb begin
        w_pa   = (int'(i_src_a_arch) < MAP_N) ? r_spec[AW'(i_src_a_arch)] : '0;
        w_pb   = (int'(i_src_b_arch) < MAP_N) ? r_spec[AW'(i_src_b_arch)] : '0;
        w_prev = (int'(i_dest_arch) < MAP_N) ? r_spec[AW'(i_dest_arch)] : '0;
        w_ba   = (int'(w_pa) < PHYS_REGS) ? r_busy[PW'(w_pa)] : 1'b0;
        w_bb   = (int'(w_pb) < PHYS_REGS) ? r_busy[PW'(w_pb)] : 1'b0;
    end

    assign w_stall  = i_has_dest && !w_found;
    assign w_nd_out = (w_stall || !i_has_dest) ? '0 : PREG_W'(w_nd);

    always_comb begin
        n_spec       = r_spec;
        n_arch       = r_arch;
        n_free       = r_free;
        n_inflight   = r_inflight;
        n_busy       = r_busy;
        w_ctl        = '0;
        w_ctl.tag    = i_branch_tag;
        n_accepted   = 1'b0;
        n_new_dest   = '0;
        n_prev_dest  = '0;
        n_src_a_phys = '0;
        n_src_a_busy = 1'b0;
        n_src_b_phys = '0;
        n_src_b_busy = 1'b0;
        case (i_op)
            OP_RENAME: begin
                n_accepted   = !w_stall;
                n_new_dest   = w_nd_out;
                n_prev_dest  = (int'(i_dest_arch) == ARCH_REGS) ? w_nd_out
                                                                : PREG_W'(w_prev);
                n_src_a_phys = PREG_W'(w_pa);
                n_src_a_busy = w_ba;
                n_src_b_phys = PREG_W'(w_pb);
                n_src_b_busy = w_bb;
                if (!w_stall) begin
                    if (i_has_dest) begin
                        n_inflight[w_nd] = 1'b1;
                        n_free[w_nd]     = 1'b0;
                        n_busy[w_nd]     = 1'b1;
                        if (int'(i_dest_arch) < MAP_N) begin
                            n_spec[AW'(i_dest_arch)] = MW'(w_nd);
                        end
                        w_ctl.alloc_en = w_take;
                    end
                    w_ctl.save_en = w_take && i_take_ckpt
                                    && (int'(i_branch_tag) < CHECKPOINTS);
                end
            end
            OP_COMMIT: begin
                n_accepted = 1'b1;
                if (i_has_dest && !i_no_free) begin
                    if (int'(i_old_phys_reg) < PHYS_REGS) begin
                        n_free[PW'(i_old_phys_reg)] = 1'b1;
                    end
                    if (int'(i_phys_reg) < PHYS_REGS) begin
                        n_inflight[PW'(i_phys_reg)] = 1'b0;
                    end
                end
                if (i_has_dest && !i_no_arch_update && int'(i_dest_arch) < MAP_N) begin
                    n_arch[AW'(i_dest_arch)] = MW'(i_phys_reg);
                end
            end
            OP_WAKE: begin
                n_accepted = 1'b1;
                if (int'(i_phys_reg) < PHYS_REGS) begin
                    n_busy[PW'(i_phys_reg)] = 1'b0;
                end
            end
            OP_RECOVER: begin
                n_accepted = 1'b1;
                if (int'(i_branch_tag) < CHECKPOINTS) begin
                    n_spec     = w_ck_map;
                    n_free     = r_free | w_ck_mask;
                    n_inflight = r_inflight & ~w_ck_mask;
                end
            end
            OP_FLUSH: begin
                n_accepted = 1'b1;
                n_spec     = r_arch;
                n_free     = r_free | r_inflight;
                n_inflight = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spec      <= w_rst_map;
            r_arch      <= w_rst_map;
            r_free      <= ~w_rst_used;
            r_inflight  <= '0;
            r_busy      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_spec     <= n_spec;
                r_arch     <= n_arch;
                r_free     <= n_free;
                r_inflight <= n_inflight;
                r_busy     <= n_busy;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_accepted   <= n_accepted;
            r_new_dest   <= n_new_dest;
            r_prev_dest  <= n_prev_dest;
            r_src_a_phys <= n_src_a_phys;
            r_src_a_busy <= n_src_a_busy;
            r_src_b_phys <= n_src_b_phys;
            r_src_b_busy <= n_src_b_busy;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_accepted   = r_accepted;
    assign o_new_dest   = r_new_dest;
    assign o_prev_dest  = r_prev_dest;
    assign o_src_a_phys = r_src_a_phys;
    assign o_src_a_busy = r_src_a_busy;
    assign o_src_b_phys = r_src_b_phys;
    assign o_src_b_busy = r_src_b_busy;

`ifndef SYNTH
    a_stall_keeps_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_op == OP_RENAME && w_stall) |=> $stable(r_free))
        else $error("stalled rename changed the free list");

    a_alloc_not_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_op == OP_RENAME && i_has_dest && w_found)
        |=> (r_free[$past(w_nd)] == 1'b0 && r_busy[$past(w_nd)] == 1'b1))
        else $error("allocated register still free or not busy");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_op == OP_FLUSH) |=> (r_inflight == '0 && r_spec == r_arch))
        else $error("flush left in-flight registers or a stale map");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_out_valid)
        else $error("request accepted without a result");
`endif

endmodule
